FILE: src/fwr_pkg.sv
// shared types and constants of the firmware image receiver
package fwr_pkg;

  localparam int unsigned InitBytes   = 8;
  localparam int unsigned DivNumW     = 39;
  localparam int unsigned DivSteps    = DivNumW;
  localparam int unsigned DivCntW     = $clog2(DivSteps + 1);
  localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [6:0]  PctMax      = 7'd100;

  localparam logic [7:0] CMD_ABORT  = 8'd0;
  localparam logic [7:0] CMD_RESET  = 8'd1;
  localparam logic [7:0] CMD_APPLY  = 8'd2;
  localparam logic [7:0] CMD_STATUS = 8'd3;

  localparam logic [1:0] CFG_MAX_SIZE     = 2'd0;
  localparam logic [1:0] CFG_CRC_EN       = 2'd1;
  localparam logic [1:0] CFG_ACK_INTERVAL = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RECV  = 3'd1,
    PH_VALID = 3'd2,
    PH_APPLY = 3'd3,
    PH_ERROR = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_INIT   = 3'd1,
    ERR_TOO_LARGE  = 3'd2,
    ERR_BEGIN_FAIL = 3'd3,
    ERR_WRITE_FAIL = 3'd4,
    ERR_CRC        = 3'd5,
    ERR_FINALIZE   = 3'd6
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INIT_CHK,
    ST_CRC,
    ST_PCT,
    ST_PCT_WAIT,
    ST_MOD_WAIT,
    ST_REPORT,
    ST_ACK,
    ST_FIN_VALID,
    ST_FIN_EMIT1,
    ST_FIN_CHECK,
    ST_FIN_EMIT2
  } ctrl_state_e;

  typedef struct packed {
    logic   in_load;
    logic   init_step;
    logic   init_clear;
    logic   load_exp;
    logic   start_recv;
    logic   full_reset;
    logic   pend_inc;
    logic   pend_clear;
    logic   crc_start;
    logic   commit;
    logic   set_err;
    err_e   err_code;
    logic   set_phase;
    phase_e phase_val;
    logic   div_start;
    logic   div_sel_mod;
    logic   pct_latch;
    logic   last_pct_upd;
    logic   out_load;
    logic   out_kind;
    logic   out_last;
  } dp_cmd_t;

  typedef struct packed {
    phase_e     phase;
    logic       op;
    logic       pkt_end;
    logic [7:0] command;
    logic       wfail;
    logic       ffail;
    logic       has_data;
    logic       init_len_ok;
    logic       size_zero;
    logic       too_large;
    logic       crc_done;
    logic       div_done;
    logic       pct_changed;
    logic       complete;
    logic       ack_en;
    logic       rem_zero;
    logic       crc_fail;
    logic       out_free;
  } dp_status_t;

endpackage

FILE: src/fwr_ctrl.sv
// controller state machine sequencing init, data, divide and report steps
module fwr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fwr_pkg::dp_status_t st_i,
  output fwr_pkg::dp_cmd_t    cmd_o
);
  import fwr_pkg::*;

  ctrl_state_e state_q, state_d;
  logic rep_q, rep_d, ack_q, ack_d, fin_q, fin_d, dend_q, dend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rep_q   <= 1'b0;
      ack_q   <= 1'b0;
      fin_q   <= 1'b0;
      dend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rep_q   <= rep_d;
      ack_q   <= ack_d;
      fin_q   <= fin_d;
      dend_q  <= dend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    rep_d      = rep_q;
    ack_d      = ack_q;
    fin_d      = fin_q;
    dend_d     = dend_q;
    cmd_o      = '0;
    cmd_o.err_code  = ERR_NONE;
    cmd_o.phase_val = PH_IDLE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          rep_d  = 1'b0;
          ack_d  = 1'b0;
          fin_d  = 1'b0;
          dend_d = 1'b0;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_IDLE;
        if (!st_i.op) begin
          if (st_i.phase == PH_IDLE) begin
            cmd_o.init_step = 1'b1;
            if (st_i.pkt_end) state_d = ST_INIT_CHK;
          end else if (st_i.phase == PH_RECV) begin
            cmd_o.pend_inc  = 1'b1;
            cmd_o.crc_start = 1'b1;
            state_d = ST_CRC;
          end
        end else begin
          case (st_i.command)
            CMD_ABORT, CMD_RESET: begin
              cmd_o.full_reset = 1'b1;
              rep_d   = 1'b1;
              state_d = ST_PCT;
            end
            CMD_APPLY: begin
              if (st_i.phase == PH_IDLE && st_i.has_data) begin
                fin_d   = 1'b1;
                state_d = ST_PCT;
              end
            end
            CMD_STATUS: begin
              rep_d   = 1'b1;
              state_d = ST_PCT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_INIT_CHK: begin
        cmd_o.init_clear = 1'b1;
        rep_d   = 1'b1;
        state_d = ST_PCT;
        if (!st_i.init_len_ok) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = ERR_BAD_INIT;
        end else begin
          cmd_o.load_exp = 1'b1;
          if (st_i.size_zero) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ERR_BAD_INIT;
          end else if (st_i.too_large) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ERR_TOO_LARGE;
          end else if (st_i.wfail) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ERR_BEGIN_FAIL;
          end else begin
            cmd_o.start_recv = 1'b1;
          end
        end
      end
      ST_CRC: begin
        if (st_i.crc_done) begin
          if (!st_i.pkt_end) begin
            state_d = ST_IDLE;
          end else if (st_i.wfail) begin
            cmd_o.pend_clear = 1'b1;
            cmd_o.set_err    = 1'b1;
            cmd_o.err_code   = ERR_WRITE_FAIL;
            rep_d   = 1'b1;
            state_d = ST_PCT;
          end else begin
            cmd_o.commit = 1'b1;
            dend_d  = 1'b1;
            state_d = ST_PCT;
          end
        end
      end
      ST_PCT: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_PCT_WAIT;
      end
      ST_PCT_WAIT: begin
        if (st_i.div_done) begin
          cmd_o.pct_latch = 1'b1;
          if (dend_q) begin
            rep_d = st_i.pct_changed || st_i.complete;
            fin_d = st_i.complete;
            cmd_o.last_pct_upd = rep_d;
            if (st_i.ack_en) begin
              cmd_o.div_start   = 1'b1;
              cmd_o.div_sel_mod = 1'b1;
              state_d = ST_MOD_WAIT;
            end else begin
              state_d = rep_d ? ST_REPORT : (fin_d ? ST_FIN_VALID : ST_IDLE);
            end
          end else begin
            state_d = rep_q ? ST_REPORT : (fin_q ? ST_FIN_VALID : ST_IDLE);
          end
        end
      end
      ST_MOD_WAIT: begin
        if (st_i.div_done) begin
          ack_d = st_i.rem_zero;
          state_d = rep_q ? ST_REPORT :
                    (ack_d ? ST_ACK : (fin_q ? ST_FIN_VALID : ST_IDLE));
        end
      end
      ST_REPORT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = !ack_q && !fin_q;
          state_d = ack_q ? ST_ACK : (fin_q ? ST_FIN_VALID : ST_IDLE);
        end
      end
      ST_ACK: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = 1'b1;
          cmd_o.out_last = !fin_q;
          state_d = fin_q ? ST_FIN_VALID : ST_IDLE;
        end
      end
      ST_FIN_VALID: begin
        cmd_o.set_phase = 1'b1;
        cmd_o.phase_val = PH_VALID;
        state_d = ST_FIN_EMIT1;
      end
      ST_FIN_EMIT1: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_FIN_CHECK;
        end
      end
      ST_FIN_CHECK: begin
        if (st_i.crc_fail) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = ERR_CRC;
        end else if (st_i.ffail) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = ERR_FINALIZE;
        end else begin
          cmd_o.set_phase = 1'b1;
          cmd_o.phase_val = PH_APPLY;
        end
        state_d = ST_FIN_EMIT2;
      end
      ST_FIN_EMIT2: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> st_i.out_free) else $error("result loaded into busy output");
  a_fin_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN_EMIT1 && st_i.out_free |=> state_q == ST_FIN_CHECK)
    else $error("finalize sequence skipped");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.in_load |=> state_q == ST_DISPATCH) else $error("accepted beat not dispatched");
`endif

endmodule

FILE: src/fwr_datapath.sv
// datapath: state registers, bit-serial crc, shared divider and output register
module fwr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic [23:0]         in_tdata_i,
  input  logic                in_tuser_i,
  input  logic                in_tlast_i,
  output logic                out_tvalid_o,
  input  logic                out_tready_i,
  output logic [111:0]        out_tdata_o,
  output logic                out_tuser_o,
  output logic                out_tlast_o,
  input  fwr_pkg::dp_cmd_t    cmd_i,
  output fwr_pkg::dp_status_t st_o
);
  import fwr_pkg::*;

  logic [31:0] max_q;
  logic        crc_en_q;
  logic [7:0]  ai_q;

  logic        op_q, end_q, wfail_q, ffail_q, has_q;
  logic [7:0]  byte_q, command_q;

  phase_e      phase_q;
  err_e        err_q;
  logic [31:0] exp_q, exp_crc_q, recv_q, crc_q, chunk_q, pend_q;
  logic [6:0]  last_pct_q, pct_q;
  logic [3:0]  init_cnt_q;
  logic [63:0] init_sh_q;
  logic [3:0]  crc_cnt_q;

  logic [DivNumW-1:0] num_q;
  logic [32:0]        rem_q;
  logic [31:0]        div_q;
  logic [DivCntW-1:0] div_cnt_q;

  logic        out_valid_q, out_kind_q, out_last_q;
  phase_e      out_phase_q;
  err_e        out_err_q;
  logic [6:0]  out_pct_q;
  logic [31:0] out_recv_q, out_exp_q, out_crc_q;

  logic [32:0]        rem_sh, rem_sub;
  logic               rem_ge;
  logic [DivNumW-1:0] num_pct;
  logic [6:0]         pct_calc;
  logic [32:0]        recv_sum;
  logic               out_free;

  assign rem_sh  = {rem_q[31:0], num_q[DivNumW-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign num_pct = ({7'd0, recv_q} << 6) + ({7'd0, recv_q} << 5) + ({7'd0, recv_q} << 2);
  assign pct_calc = (exp_q == 32'd0) ? 7'd0 :
                    (num_q > DivNumW'(PctMax)) ? PctMax : num_q[6:0];
  assign recv_sum = {1'b0, recv_q} + {1'b0, pend_q};
  assign out_free = !out_valid_q || out_tready_i;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= 32'd1048576;
      crc_en_q <= 1'b1;
      ai_q     <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_SIZE:     max_q    <= cfg_wdata_i;
        CFG_CRC_EN:       crc_en_q <= cfg_wdata_i[0];
        CFG_ACK_INTERVAL: ai_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q      <= in_tuser_i;
      end_q     <= in_tlast_i;
      byte_q    <= in_tdata_i[7:0];
      command_q <= in_tdata_i[15:8];
      wfail_q   <= in_tdata_i[16];
      ffail_q   <= in_tdata_i[17];
      has_q     <= in_tdata_i[18];
    end
  end

  // engine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      err_q      <= ERR_NONE;
      exp_q      <= '0;
      exp_crc_q  <= '0;
      recv_q     <= '0;
      crc_q      <= CrcInit;
      last_pct_q <= '0;
      chunk_q    <= '0;
      pend_q     <= '0;
      init_cnt_q <= '0;
      init_sh_q  <= '0;
      crc_cnt_q  <= '0;
      pct_q      <= '0;
    end else begin
      if (cmd_i.full_reset) begin
        phase_q    <= PH_IDLE;
        err_q      <= ERR_NONE;
        exp_q      <= '0;
        exp_crc_q  <= '0;
        recv_q     <= '0;
        crc_q      <= CrcInit;
        last_pct_q <= '0;
        chunk_q    <= '0;
        pend_q     <= '0;
        init_cnt_q <= '0;
        init_sh_q  <= '0;
      end
      if (cmd_i.init_step) begin
        if (init_cnt_q < 4'(InitBytes)) init_sh_q[{init_cnt_q[2:0], 3'b000} +: 8] <= byte_q;
        if (init_cnt_q <= 4'(InitBytes)) init_cnt_q <= init_cnt_q + 4'd1;
      end
      if (cmd_i.init_clear) begin
        init_cnt_q <= '0;
        init_sh_q  <= '0;
      end
      if (cmd_i.load_exp) begin
        exp_q     <= init_sh_q[31:0];
        exp_crc_q <= init_sh_q[63:32];
      end
      if (cmd_i.start_recv) begin
        recv_q     <= '0;
        crc_q      <= CrcInit;
        last_pct_q <= '0;
        chunk_q    <= '0;
        pend_q     <= '0;
        phase_q    <= PH_RECV;
      end
      if (cmd_i.pend_inc && pend_q != 32'hFFFF_FFFF) pend_q <= pend_q + 32'd1;
      if (cmd_i.pend_clear) pend_q <= '0;
      if (cmd_i.commit) begin
        recv_q  <= recv_sum[32] ? 32'hFFFF_FFFF : recv_sum[31:0];
        pend_q  <= '0;
        chunk_q <= chunk_q + 32'd1;
      end
      if (cmd_i.crc_start) begin
        if (crc_en_q) begin
          crc_q     <= crc_q ^ {24'd0, byte_q};
          crc_cnt_q <= 4'd8;
        end
      end else if (crc_cnt_q != 4'd0) begin
        crc_q     <= crc_q[0] ? ((crc_q >> 1) ^ CrcPoly) : (crc_q >> 1);
        crc_cnt_q <= crc_cnt_q - 4'd1;
      end
      if (cmd_i.set_err) begin
        err_q   <= cmd_i.err_code;
        phase_q <= PH_ERROR;
      end
      if (cmd_i.set_phase) phase_q <= cmd_i.phase_val;
      if (cmd_i.pct_latch) pct_q <= pct_calc;
      if (cmd_i.last_pct_upd) last_pct_q <= pct_calc;
    end
  end

  // shared bit-serial divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= DivCntW'(DivSteps);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      if (cmd_i.div_sel_mod) begin
        num_q <= {7'd0, chunk_q};
        div_q <= {24'd0, ai_q};
      end else begin
        num_q <= num_pct;
        div_q <= exp_q;
      end
    end else if (div_cnt_q != '0) begin
      rem_q <= rem_ge ? rem_sub : rem_sh;
      num_q <= {num_q[DivNumW-2:0], rem_ge};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_last_q <= cmd_i.out_last;
      if (cmd_i.out_kind) begin
        out_phase_q <= PH_IDLE;
        out_err_q   <= ERR_NONE;
        out_pct_q   <= '0;
        out_recv_q  <= '0;
        out_exp_q   <= '0;
        out_crc_q   <= '0;
      end else begin
        out_phase_q <= phase_q;
        out_err_q   <= err_q;
        out_pct_q   <= pct_q;
        out_recv_q  <= recv_q;
        out_exp_q   <= exp_q;
        out_crc_q   <= crc_q ^ CrcInit;
      end
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tuser_o  = out_kind_q;
  assign out_tlast_o  = out_last_q;
  assign out_tdata_o  = {3'd0, out_crc_q, out_exp_q, out_recv_q, out_pct_q,
                         out_err_q, out_phase_q};

  always_comb begin
    st_o.phase       = phase_q;
    st_o.op          = op_q;
    st_o.pkt_end     = end_q;
    st_o.command     = command_q;
    st_o.wfail       = wfail_q;
    st_o.ffail       = ffail_q;
    st_o.has_data    = has_q;
    st_o.init_len_ok = init_cnt_q == 4'(InitBytes);
    st_o.size_zero   = init_sh_q[31:0] == 32'd0;
    st_o.too_large   = init_sh_q[31:0] > max_q;
    st_o.crc_done    = crc_cnt_q == 4'd0;
    st_o.div_done    = div_cnt_q == '0;
    st_o.pct_changed = pct_calc != last_pct_q;
    st_o.complete    = recv_q >= exp_q;
    st_o.ack_en      = ai_q != 8'd0;
    st_o.rem_zero    = rem_q == 33'd0;
    st_o.crc_fail    = crc_en_q && exp_crc_q != 32'd0 && (crc_q ^ CrcInit) != exp_crc_q;
    st_o.out_free    = out_free;
  end

`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_pct_q <= PctMax) else $error("percent above limit");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> div_cnt_q == '0) else $error("divider restarted while busy");
  a_crc_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_cnt_q != 4'd0 |-> phase_q == PH_RECV) else $error("crc running outside receive");
`endif

endmodule

FILE: src/firmware_image_receiver.sv
// top level of the firmware image receiver
// Usage:
//   The slave stream carries one beat per byte or command. tuser selects a data
//   byte (0) or a control command (1); tlast marks the last byte of a data packet.
//   In idle, an 8-byte init packet gives size and CRC-32, little-endian; later
//   packets carry the image, checked with a bit-serial CRC-32.
//   The master stream carries result beats: tuser 0 is a progress report, 1 an
//   ack; tlast marks the last result caused by one input beat.
//   Timing: a data byte of the image runs through the CRC one bit per cycle; the first
//   result of a command or a packet end waits on the 39-step bit-serial divider, shared
//   by the percent and the ack interval; a packet end with acks runs the divider twice.
//   One item is in work at a time; the next beat is taken once the last result
//   of the previous one sits in the output register.
//   A stalled master side holds the output register and the engine waits there.
//   Reset clears the engine to idle, the limit to 1 MiB, CRC checking on, acks off.
//   Configuration is to be written on cfg_we_i while no beat is in work (not enforced).
module firmware_image_receiver (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // data_byte[7:0], command[15:8], write_fail[16], finalize_fail[17],
  // storage_has_data[18], zero fill
  input  logic [23:0]  s_axis_tdata_i,
  // op
  input  logic         s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status_state[2:0], error_code[5:3], percent[12:6], bytes_received[44:13],
  // bytes_expected[76:45], crc_value[108:77], zero fill
  output logic [111:0] m_axis_tdata_o,
  // kind
  output logic         m_axis_tuser_o,
  output logic         m_axis_tlast_o
);
  import fwr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  fwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fwr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_tdata_i   (s_axis_tdata_i),
    .in_tuser_i   (s_axis_tuser_i),
    .in_tlast_i   (s_axis_tlast_i),
    .out_tvalid_o (m_axis_tvalid_o),
    .out_tready_i (m_axis_tready_i),
    .out_tdata_o  (m_axis_tdata_o),
    .out_tuser_o  (m_axis_tuser_o),
    .out_tlast_o  (m_axis_tlast_o),
    .cmd_i        (cmd),
    .st_o         (st)
  );

endmodule

FILE: test/firmware_image_receiver_tb.sv
// testbench of the firmware image receiver: directed table, then random packets, checked against a model
`timescale 1ns / 100ps

module firmware_image_receiver_tb;
  import fwr_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned TailCycles    = 200;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       pkt_end;
    logic [7:0] command;
    logic       wfail;
    logic       ffail;
    logic       has_data;
  } beat_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  state;
    logic [2:0]  err;
    logic [6:0]  pct;
    logic [31:0] rcvd;
    logic [31:0] expd;
    logic [31:0] crc;
    logic        last;
  } report_t;

  typedef struct {
    beat_t   b;
    logic    chk;
    report_t r;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [31:0]  cfg_wdata_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [23:0]  s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         s_axis_tlast_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [111:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         m_axis_tlast_o;

  firmware_image_receiver dut (.*);

  // model state
  logic [31:0] max_size_q, ack_ivl_q;
  logic        crc_en_q;
  phase_e      ph;
  err_e        err_q;
  logic [31:0] exp_size, exp_crc, rcvd_cnt, crc_run, chunks, pend;
  logic [6:0]  last_pct;
  logic [3:0]  init_cnt;
  logic [63:0] init_sh;

  report_t     expected_reports[$];
  report_t     step_out[$];
  int unsigned errors;
  int unsigned idle_cycles;
  logic        hold_off;
  logic        rx_no_idle, tx_no_idle;

  function automatic logic [6:0] pct_now();
    logic [63:0] p;
    if (exp_size == 0) return 7'd0;
    p = (64'(rcvd_cnt) * 64'd100) / 64'(exp_size);
    return (p > 100) ? 7'd100 : p[6:0];
  endfunction

  function automatic void push_report(logic kind);
    report_t r;
    r = '0;
    r.kind = kind;
    if (!kind) begin
      r.state = ph; r.err = err_q; r.pct = pct_now();
      r.rcvd = rcvd_cnt; r.expd = exp_size; r.crc = ~crc_run;
    end
    if (step_out.size() < 4) step_out.push_back(r);
  endfunction

  function automatic void fail_with(err_e e);
    err_q = e; ph = PH_ERROR; push_report(1'b0);
  endfunction

  function automatic void clear_engine();
    ph = PH_IDLE; err_q = ERR_NONE; exp_size = 0; exp_crc = 0; rcvd_cnt = 0;
    crc_run = CrcInit; last_pct = 0; chunks = 0; init_cnt = 0; init_sh = 0; pend = 0;
  endfunction

  function automatic void validate(logic ff);
    ph = PH_VALID; push_report(1'b0);
    if (crc_en_q && exp_crc != 0 && ~crc_run != exp_crc) begin
      fail_with(ERR_CRC); return;
    end
    if (ff) begin
      fail_with(ERR_FINALIZE); return;
    end
    ph = PH_APPLY; push_report(1'b0);
  endfunction

  function automatic logic [31:0] crc_next_byte(logic [31:0] c, logic [7:0] d);
    c ^= {24'd0, d};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  // runs one beat through the model, results left in step_out
  function automatic void predict_beat(beat_t b);
    logic [6:0] cur;
    step_out.delete();
    if (!b.op) begin
      if (ph == PH_IDLE) begin
        if (init_cnt < InitBytes) init_sh |= 64'(b.data_byte) << (8 * init_cnt[2:0]);
        if (init_cnt <= InitBytes) init_cnt++;
        if (b.pkt_end) begin
          if (init_cnt != InitBytes) begin
            init_cnt = 0; init_sh = 0; fail_with(ERR_BAD_INIT);
          end else begin
            exp_size = init_sh[31:0]; exp_crc = init_sh[63:32];
            init_cnt = 0; init_sh = 0;
            if (exp_size == 0) fail_with(ERR_BAD_INIT);
            else if (exp_size > max_size_q) fail_with(ERR_TOO_LARGE);
            else if (b.wfail) fail_with(ERR_BEGIN_FAIL);
            else begin
              rcvd_cnt = 0; crc_run = CrcInit; last_pct = 0; chunks = 0; pend = 0;
              ph = PH_RECV; push_report(1'b0);
            end
          end
        end
      end else if (ph == PH_RECV) begin
        if (crc_en_q) crc_run = crc_next_byte(crc_run, b.data_byte);
        if (pend != '1) pend++;
        if (b.pkt_end) begin
          if (b.wfail) begin
            pend = 0; fail_with(ERR_WRITE_FAIL);
          end else begin
            rcvd_cnt = ('1 - rcvd_cnt < pend) ? '1 : rcvd_cnt + pend;
            pend = 0; chunks++;
            cur = pct_now();
            if (cur != last_pct || rcvd_cnt >= exp_size) begin
              last_pct = cur; push_report(1'b0);
            end
            if (ack_ivl_q != 0 && chunks % ack_ivl_q == 0) push_report(1'b1);
            if (rcvd_cnt >= exp_size) validate(b.ffail);
          end
        end
      end
    end else if (b.command == CMD_ABORT || b.command == CMD_RESET) begin
      clear_engine(); push_report(1'b0);
    end else if (b.command == CMD_APPLY) begin
      if (ph == PH_IDLE && b.has_data) validate(b.ffail);
    end else if (b.command == CMD_STATUS) begin
      push_report(1'b0);
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // output side: random stalls, long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) m_axis_tready_i <= 1'b0;
      else m_axis_tready_i <= rx_no_idle || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      report_t got, want;
      got = {m_axis_tuser_o, m_axis_tdata_o[2:0], m_axis_tdata_o[5:3], m_axis_tdata_o[12:6],
             m_axis_tdata_o[44:13], m_axis_tdata_o[76:45], m_axis_tdata_o[108:77],
             m_axis_tlast_o};
      if (expected_reports.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (got.kind != want.kind) begin
          $error("kind exp %0d got %0d", want.kind, got.kind); errors++;
        end
        if (got.state != want.state) begin
          $error("status_state exp %0d got %0d", want.state, got.state); errors++;
        end
        if (got.err != want.err) begin
          $error("error_code exp %0d got %0d", want.err, got.err); errors++;
        end
        if (got.pct != want.pct) begin
          $error("percent exp %0d got %0d", want.pct, got.pct); errors++;
        end
        if (got.rcvd != want.rcvd) begin
          $error("bytes_received exp %0d got %0d", want.rcvd, got.rcvd); errors++;
        end
        if (got.expd != want.expd) begin
          $error("bytes_expected exp %0d got %0d", want.expd, got.expd); errors++;
        end
        if (got.crc != want.crc) begin
          $error("crc_value exp %h got %h", want.crc, got.crc); errors++;
        end
        if (got.last != want.last) begin
          $error("last exp %0d got %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(beat_t b);
    while (!tx_no_idle && $urandom_range(99) < 38) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = b.op;
    s_axis_tlast_i  = b.pkt_end;
    s_axis_tdata_i  = {5'd0, b.has_data, b.ffail, b.wfail, b.command, b.data_byte};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_beat(b);
    foreach (step_out[i]) expected_reports.push_back(step_out[i]);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic drain();
    while (expected_reports.size() > 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_SIZE:     max_size_q = val;
      CFG_CRC_EN:       crc_en_q = val[0];
      CFG_ACK_INTERVAL: ack_ivl_q = {24'd0, val[7:0]};
      default: ;
    endcase
  endtask

  function automatic beat_t data_beat(logic [7:0] d, logic e);
    beat_t b;
    b = '0;
    b.data_byte = d; b.pkt_end = e;
    b.command = 8'($urandom); b.has_data = 1'($urandom);
    return b;
  endfunction

  function automatic beat_t cmd_beat(logic [7:0] c, logic ff, logic hd);
    beat_t b;
    b = '0;
    b.op = 1'b1; b.command = c; b.ffail = ff; b.has_data = hd;
    b.data_byte = 8'($urandom); b.pkt_end = 1'($urandom);
    return b;
  endfunction

  task automatic send_init(logic [31:0] size, logic [31:0] crc, int n, logic wf);
    logic [63:0] v;
    beat_t b;
    v = {crc, size};
    for (int i = 0; i < n; i++) begin
      b = data_beat(v[8 * (i % 8) +: 8], i == n - 1);
      b.wfail = (i == n - 1) ? wf : 1'($urandom);
      send_beat(b);
    end
  endtask

  // random image: init, packets of random bytes, mostly a correct crc
  task automatic send_image(int size);
    logic [7:0]  img[$];
    logic [31:0] c;
    int          k, plen;
    beat_t       b;
    img.delete();
    c = CrcInit;
    for (int i = 0; i < size; i++) begin
      img.push_back(8'($urandom));
      c = crc_next_byte(c, img[i]);
    end
    send_init(size, ($urandom_range(3) == 0) ? 32'($urandom) : ~c, 8,
              $urandom_range(19) == 0);
    k = 0;
    while (k < size) begin
      plen = $urandom_range(1, 6);
      for (int j = 0; j < plen && k < size; j++, k++) begin
        b = data_beat(img[k], j == plen - 1 || k == size - 1);
        b.wfail = b.pkt_end && ($urandom_range(29) == 0);
        b.ffail = $urandom_range(4) == 0;
        send_beat(b);
      end
    end
  endtask

  row_t table_q[$];

  function automatic report_t mk(phase_e s, err_e e, logic [31:0] x);
    report_t r;
    r = '0;
    r.state = s; r.err = e; r.expd = x; r.crc = 32'd0; r.last = 1'b1;
    return r;
  endfunction

  initial begin
    beat_t b;
    row_t  rw;
    errors = 0; idle_cycles = 0; hold_off = 1'b0;
    rx_no_idle = 1'b0; tx_no_idle = 1'b0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = CFG_MAX_SIZE; cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0; s_axis_tdata_i = '0; s_axis_tuser_i = 1'b0; s_axis_tlast_i = 1'b0;
    max_size_q = 32'd1048576; crc_en_q = 1'b1; ack_ivl_q = 32'd0;
    clear_engine();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: status, short init, commands; then zero size and too large inits
    table_q = '{
      '{cmd_beat(CMD_STATUS, 1'b0, 1'b0), 1'b1, mk(PH_IDLE, ERR_NONE, 32'd0)},
      '{data_beat(8'hFF, 1'b1), 1'b1, mk(PH_ERROR, ERR_BAD_INIT, 32'd0)},
      '{cmd_beat(CMD_RESET, 1'b0, 1'b0), 1'b1, mk(PH_IDLE, ERR_NONE, 32'd0)},
      '{cmd_beat(8'hFF, 1'b0, 1'b1), 1'b0, '0},
      '{cmd_beat(CMD_APPLY, 1'b0, 1'b0), 1'b0, '0},
      '{cmd_beat(CMD_APPLY, 1'b1, 1'b1), 1'b0, '0},
      '{cmd_beat(CMD_ABORT, 1'b0, 1'b0), 1'b1, mk(PH_IDLE, ERR_NONE, 32'd0)},
      '{cmd_beat(CMD_APPLY, 1'b0, 1'b1), 1'b0, '0},
      '{data_beat(8'h00, 1'b0), 1'b0, '0},
      '{cmd_beat(CMD_ABORT, 1'b0, 1'b0), 1'b1, mk(PH_IDLE, ERR_NONE, 32'd0)}
    };
    foreach (table_q[i]) begin
      rw = table_q[i];
      send_beat(rw.b);
      if (rw.chk && (step_out.size() != 1 || step_out[0] != rw.r)) begin
        $error("table row %0d: model and table disagree", i); errors++;
      end
    end
    send_init(32'd0, 32'd0, 8, 1'b0);
    send_beat(cmd_beat(CMD_RESET, 1'b0, 1'b0));
    send_init(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8, 1'b0);
    send_beat(cmd_beat(CMD_RESET, 1'b0, 1'b0));
    send_init(32'd4, 32'd0, 10, 1'b0);
    send_beat(cmd_beat(CMD_RESET, 1'b0, 1'b0));
    send_init(32'd2, 32'hCBF4_3926, 8, 1'b1);
    send_beat(cmd_beat(CMD_ABORT, 1'b0, 1'b0));

    write_cfg(CFG_ACK_INTERVAL, 32'd1);
    write_cfg(CFG_MAX_SIZE, 32'd40);
    for (int n = 0; n < 14; n++) begin
      if (n == 2) write_cfg(CFG_CRC_EN, 32'd0);
      if (n == 4) write_cfg(CFG_CRC_EN, 32'd1);
      if (n == 5) write_cfg(CFG_ACK_INTERVAL, 32'd255);
      if (n == 7) write_cfg(CFG_ACK_INTERVAL, 32'd2);
      if (n == 9) write_cfg(CFG_MAX_SIZE, 32'hFFFF_FFFF);
      if (n == 11) write_cfg(CFG_MAX_SIZE, 32'd1);
      if (n == 12) write_cfg(CFG_MAX_SIZE, 32'd30);
      if (n == 6) tx_no_idle = 1'b1;
      if (n == 9) tx_no_idle = 1'b0;
      if (n == 3) rx_no_idle = 1'b1;
      if (n == 5) rx_no_idle = 1'b0;
      if (n == 1) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      if (n == 4) drain();
      send_image($urandom_range(1, 12));
      case ($urandom_range(4))
        0: send_beat(cmd_beat(CMD_STATUS, 1'($urandom), 1'($urandom)));
        1: send_beat(cmd_beat(8'($urandom), 1'($urandom), 1'($urandom)));
        2: send_beat(data_beat(8'($urandom), 1'($urandom)));
        default: ;
      endcase
      send_beat(cmd_beat($urandom_range(1) ? CMD_ABORT : CMD_RESET,
                         1'($urandom), 1'($urandom)));
      if ($urandom_range(2) == 0)
        send_beat(cmd_beat(CMD_APPLY, 1'($urandom), 1'($urandom)));
      if ($urandom_range(3) == 0) begin
        send_init($urandom, $urandom, $urandom_range(1, 10), 1'($urandom));
        send_beat(cmd_beat(CMD_ABORT, 1'b0, 1'b0));
      end
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
